@@ hdl/mck_pkg.sv @@
// mck_pkg: shared types, codes and the character code table of the morse keyer
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNMAPPED  = 2'd1;
    localparam logic [1:0] ST_SKIPPED   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DIT      = 2'd0;
    localparam logic [1:0] REG_ELEM_GAP = 2'd1;
    localparam logic [1:0] REG_LTR_GAP  = 2'd2;
    localparam logic [1:0] REG_WORD_GAP = 2'd3;

    // register reset values
    localparam logic [15:0] DIT_RST      = 16'd240;
    localparam logic [15:0] ELEM_GAP_RST = 16'd240;
    localparam logic [15:0] LTR_GAP_RST  = 16'd2880;
    localparam logic [15:0] WORD_GAP_RST = 16'd6720;

    localparam logic [7:0] CHAR_BLANK = 8'h20;

    // element group codes
    localparam logic [1:0] GRP_DOT  = 2'd1;
    localparam logic [1:0] GRP_DASH = 2'd2;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CODE_W = 12;
    localparam int DUR_W  = 18;

    typedef enum logic [1:0] {
        K_ABORT = 2'd0,
        K_BLANK = 2'd1,
        K_CHAR  = 2'd2
    } t_kind;

    // one classified character, front to back
    typedef struct packed {
        t_kind               kind;
        logic                pend;
        logic [CODE_W-1:0]   code;
    } t_cmd;

    typedef struct packed {
        logic [15:0] dit;
        logic [15:0] elem_gap;
        logic [15:0] ltr_gap;
        logic [15:0] word_gap;
    } t_cfg;

    // element code of a character, zero when unmapped
    function automatic logic [CODE_W-1:0] char_code(input logic [7:0] ch);
        logic [CODE_W-1:0] c;
        case (ch)
            8'h2E: c = 12'h999;
            8'h30: c = 12'h2AA;
            8'h31: c = 12'h2A9;
            8'h32: c = 12'h2A5;
            8'h33: c = 12'h295;
            8'h34: c = 12'h255;
            8'h35: c = 12'h155;
            8'h36: c = 12'h156;
            8'h37: c = 12'h15A;
            8'h38: c = 12'h16A;
            8'h39: c = 12'h1AA;
            8'h41: c = 12'h009;
            8'h42: c = 12'h056;
            8'h43: c = 12'h066;
            8'h44: c = 12'h016;
            8'h45: c = 12'h001;
            8'h46: c = 12'h065;
            8'h47: c = 12'h01A;
            8'h48: c = 12'h055;
            8'h49: c = 12'h005;
            8'h4A: c = 12'h0A9;
            8'h4B: c = 12'h026;
            8'h4C: c = 12'h059;
            8'h4D: c = 12'h00A;
            8'h4E: c = 12'h006;
            8'h4F: c = 12'h02A;
            8'h50: c = 12'h069;
            8'h51: c = 12'h09A;
            8'h52: c = 12'h019;
            8'h53: c = 12'h015;
            8'h54: c = 12'h002;
            8'h55: c = 12'h025;
            8'h56: c = 12'h095;
            8'h57: c = 12'h029;
            8'h58: c = 12'h096;
            8'h59: c = 12'h0A6;
            8'h5A: c = 12'h05A;
            default: c = '0;
        endcase
        return c;
    endfunction

    // a code sends cleanly when nonzero and every group up to the top one is a dot or dash
    function automatic logic code_ok(input logic [CODE_W-1:0] c);
        logic       ok;
        logic [1:0] g;
        logic       hi;
        ok = (c != '0);
        for (int i = 0; i < CODE_W / 2; i++) begin
            g  = c[2*i +: 2];
            hi = ((c >> (2*i + 2)) != '0);
            if (g == 2'd3 || (g == 2'd0 && hi)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ hdl/mck_in_if.sv @@
// mck_in_if: character channel, one character and its message-start flag per beat
`timescale 1ns / 1ps
`default_nettype none

interface mck_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       first_of_message;

    modport source (output valid, output character, output first_of_message, input ready);
    modport sink   (input valid, input character, input first_of_message, output ready);
endinterface

`default_nettype wire

@@ hdl/mck_out_if.sv @@
// mck_out_if: key segment channel, one segment per beat
`timescale 1ns / 1ps
`default_nettype none

interface mck_out_if;
    logic        valid;
    logic        ready;
    logic        key_on;
    logic [17:0] duration_ms;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output key_on, output duration_ms, output status,
                    output last, input ready);
    modport sink   (input valid, input key_on, input duration_ms, input status,
                    input last, output ready);
endinterface

`default_nettype wire

@@ hdl/mck_front.sv @@
// mck_front: accepts characters, tracks message flags and classifies each character
`timescale 1ns / 1ps
`default_nettype none

module mck_front (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mck_in_if.sink       i_char,
    input  wire          i_q_full,
    output logic         o_push,
    output mck_pkg::t_cmd o_cmd
);

    logic r_letter_pending;
    logic r_aborted;
    logic n_letter_pending;
    logic n_aborted;

    logic               accept;
    logic               eff_pend;
    logic               eff_abort;
    logic [mck_pkg::CODE_W-1:0] code;

    assign i_char.ready = !i_q_full;
    assign accept       = i_char.valid && !i_q_full;
    assign o_push       = accept;

    // message start clears both flags before classification
    assign eff_pend  = i_char.first_of_message ? 1'b0 : r_letter_pending;
    assign eff_abort = i_char.first_of_message ? 1'b0 : r_aborted;
    assign code      = mck_pkg::char_code(i_char.character);

    // classify and work out the flags this character leaves
    always_comb begin
        n_letter_pending = eff_pend;
        n_aborted        = eff_abort;
        o_cmd.pend       = eff_pend;
        o_cmd.code       = code;
        if (eff_abort) begin
            o_cmd.kind = mck_pkg::K_ABORT;
        end else if (i_char.character == mck_pkg::CHAR_BLANK) begin
            o_cmd.kind       = mck_pkg::K_BLANK;
            n_letter_pending = 1'b0;
        end else begin
            o_cmd.kind = mck_pkg::K_CHAR;
            if (mck_pkg::code_ok(code)) begin
                n_letter_pending = 1'b1;
            end else begin
                n_aborted = 1'b1;
            end
        end
    end

    // flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter_pending <= 1'b0;
            r_aborted        <= 1'b0;
        end else if (accept) begin
            r_letter_pending <= n_letter_pending;
            r_aborted        <= n_aborted;
        end
    end

    // a blank outside an aborted message leaves the letter flag cleared
    a_blank_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !eff_abort && i_char.character == mck_pkg::CHAR_BLANK |=> !r_letter_pending)
        else $error("letter flag set after blank");

endmodule

`default_nettype wire

@@ hdl/mck_queue.sv @@
// mck_queue: short command queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module mck_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  mck_pkg::t_cmd i_cmd,
    input  wire           i_pop,
    output mck_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_avail
);

    mck_pkg::t_cmd r_mem [mck_pkg::QUEUE_DEPTH];
    logic [mck_pkg::PTR_W-1:0] r_wr;
    logic [mck_pkg::PTR_W-1:0] r_rd;
    logic [mck_pkg::CNT_W-1:0] r_cnt;

    function automatic logic [mck_pkg::PTR_W-1:0] ptr_inc(input logic [mck_pkg::PTR_W-1:0] p);
        return (p == mck_pkg::PTR_W'(mck_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == mck_pkg::CNT_W'(mck_pkg::QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_avail))
        else $error("queue overflow or underflow");

endmodule

`default_nettype wire

@@ hdl/mck_back.sv @@
// mck_back: segment sequencer with the output register
`timescale 1ns / 1ps
`default_nettype none

module mck_back (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  mck_pkg::t_cfg i_cfg,
    input  mck_pkg::t_cmd i_cmd,
    input  wire           i_cmd_avail,
    output logic          o_cmd_pop,
    mck_out_if.source     o_seg
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LGAP = 6'b000010,
        S_EGAP = 6'b000100,
        S_ELEM = 6'b001000,
        S_ERR  = 6'b010000,
        S_ONE  = 6'b100000
    } t_bstate;

    t_bstate r_state;
    t_bstate n_state;

    mck_pkg::t_kind             r_kind;
    logic [mck_pkg::CODE_W-1:0] r_code;
    logic [mck_pkg::CODE_W-1:0] n_code;

    logic                       r_out_valid;
    logic                       r_key_on;
    logic [mck_pkg::DUR_W-1:0]  r_dur;
    logic [1:0]                 r_status;
    logic                       r_last;

    logic                       can_emit;
    logic                       emit;
    logic                       n_key_on;
    logic [mck_pkg::DUR_W-1:0]  n_dur;
    logic [1:0]                 n_status;
    logic                       n_last;
    logic [1:0]                 grp;
    logic [mck_pkg::CODE_W-1:0] code_rest;
    logic [mck_pkg::DUR_W-1:0]  dash_dur;

    assign can_emit  = !r_out_valid || o_seg.ready;
    assign grp       = r_code[1:0];
    assign code_rest = r_code >> 2;
    assign dash_dur  = {1'b0, i_cfg.dit, 1'b0} + {2'b00, i_cfg.dit};
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_avail;

    // sequencer: one segment per cycle while the output slot is free
    always_comb begin
        n_state  = r_state;
        n_code   = r_code;
        emit     = 1'b0;
        n_key_on = 1'b0;
        n_dur    = '0;
        n_status = mck_pkg::ST_OK;
        n_last   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_code = i_cmd.code;
                if (i_cmd_avail) begin
                    if (i_cmd.kind != mck_pkg::K_CHAR) begin
                        n_state = S_ONE;
                    end else if (i_cmd.pend) begin
                        n_state = S_LGAP;
                    end else if (i_cmd.code == '0) begin
                        n_state = S_ERR;
                    end else begin
                        n_state = S_ELEM;
                    end
                end
            end
            S_LGAP: begin
                n_dur = {2'b00, i_cfg.ltr_gap};
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = (r_code == '0) ? S_ERR : S_ELEM;
                end
            end
            S_EGAP: begin
                n_dur = {2'b00, i_cfg.elem_gap};
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_ELEM;
                end
            end
            S_ELEM: begin
                n_key_on = 1'b1;
                n_dur    = (grp == mck_pkg::GRP_DASH) ? dash_dur : {2'b00, i_cfg.dit};
                n_last   = (code_rest == '0);
                if (grp != mck_pkg::GRP_DOT && grp != mck_pkg::GRP_DASH) begin
                    n_state = S_ERR;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    n_code  = code_rest;
                    n_state = (code_rest == '0) ? S_IDLE : S_EGAP;
                end
            end
            S_ERR: begin
                n_status = mck_pkg::ST_UNMAPPED;
                n_last   = 1'b1;
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ONE: begin
                n_last = 1'b1;
                if (r_kind == mck_pkg::K_BLANK) begin
                    n_dur = {2'b00, i_cfg.word_gap};
                end else begin
                    n_status = mck_pkg::ST_SKIPPED;
                end
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and command registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        if (o_cmd_pop) begin
            r_kind <= i_cmd.kind;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_seg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_key_on <= n_key_on;
            r_dur    <= n_dur;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    assign o_seg.valid       = r_out_valid;
    assign o_seg.key_on      = r_key_on;
    assign o_seg.duration_ms = r_dur;
    assign o_seg.status      = r_status;
    assign o_seg.last        = r_last;

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != mck_pkg::ST_OK |-> r_last && !r_key_on && r_dur == '0)
        else $error("status beat not a closing zero-length beat");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_state != S_IDLE)
        else $error("sequencer stayed idle after taking a command");

endmodule

`default_nettype wire

@@ hdl/morse_code_keyer_core.sv @@
// morse_code_keyer_core: top level of the morse keyer, config registers and part wiring
//
// Usage:
//   i_char carries one ASCII character per beat with a message-start flag.
//   o_seg carries key segments: key level, duration in ms, status, last flag.
//   A character gives one to twelve segments; the one flagged last closes it.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) set dit length and gaps; the user
//   makes them only while no character is in flight; the block leaves this unchecked.
// Timing:
//   the front classifies a character in the cycle it is accepted and queues it
//   in a two-entry command queue; the back loads a command in its idle state,
//   then emits one segment per cycle while the output slot is free and takes
//   the next command only on its return to idle; the first segment goes through
//   the queue, the idle load and the output register; the back sequencer sets the rate.
// Reset:
//   synchronous, clears the message flags, the queue and the output slot and
//   loads the default register values.
// Stall:
//   when o_seg.ready is low the output register holds its beat, the back
//   waits, and once the queue fills i_char.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module morse_code_keyer_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mck_in_if.sink     i_char,
    mck_out_if.source  o_seg,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [15:0] i_cfg_data
);

    mck_pkg::t_cfg r_cfg;
    mck_pkg::t_cmd push_cmd;
    mck_pkg::t_cmd pop_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_avail;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dit      <= mck_pkg::DIT_RST;
            r_cfg.elem_gap <= mck_pkg::ELEM_GAP_RST;
            r_cfg.ltr_gap  <= mck_pkg::LTR_GAP_RST;
            r_cfg.word_gap <= mck_pkg::WORD_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mck_pkg::REG_DIT:      r_cfg.dit      <= i_cfg_data;
                mck_pkg::REG_ELEM_GAP: r_cfg.elem_gap <= i_cfg_data;
                mck_pkg::REG_LTR_GAP:  r_cfg.ltr_gap  <= i_cfg_data;
                mck_pkg::REG_WORD_GAP: r_cfg.word_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify
    mck_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // command queue
    mck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_full  (q_full),
        .o_avail (q_avail)
    );

    // back: segment sequencer
    mck_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (pop_cmd),
        .i_cmd_avail (q_avail),
        .o_cmd_pop   (pop),
        .o_seg       (o_seg)
    );

endmodule

`default_nettype wire
